// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property check, disabled during reset
`define FPRC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Next-cycle implication, disabled during reset
`define FPRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FPRC_ASSERT(lbl, clk, rst, prop, msg)
`define FPRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/fprc_pkg.sv
// ---------------------------------------------------------------------------
// fprc_pkg
// Constants, codes, the packet summary struct and the CRC-32 byte update.
// ---------------------------------------------------------------------------
package fprc_pkg;

   // Packet framing
   localparam int HEADER_BYTES        = 18;
   localparam int CRC_BYTES           = 4;
   localparam int MIN_BYTES           = HEADER_BYTES + CRC_BYTES;
   localparam int MAX_PAYLOAD_DEFAULT = 128;

   // Reflected CRC-32
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Reply codes
   localparam logic REPLY_ACK  = 1'b0;
   localparam logic REPLY_NACK = 1'b1;

   // Ordering status codes
   localparam logic [1:0] ORDER_IN_SEQ      = 2'd0;
   localparam logic [1:0] ORDER_GAP         = 2'd1;
   localparam logic [1:0] ORDER_STALE       = 2'd2;
   localparam logic [1:0] ORDER_NOT_CHECKED = 2'd3;

   // Summary of a packet at its last byte
   typedef struct packed {
      logic        judge;      // last byte taken, packet long enough
      logic        len_ok;     // length field consistent
      logic        crc_ok;     // computed CRC matches trailer
      logic [31:0] transfer;
      logic [31:0] sequence_no;
      logic [31:0] total;
   } pkt_type;

   // One byte through the reflected CRC-32, bit at a time
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_i, input logic [7:0] b);
      logic [31:0] c;
      c = crc_i ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// File: rtl/fprc_parser.sv
// ---------------------------------------------------------------------------
// fprc_parser
// Per-packet byte tracking: header capture, CRC over delayed bytes, trailer.
// ---------------------------------------------------------------------------
module fprc_parser
   import fprc_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output pkt_type    pkt
);

   localparam int          FULL_BYTES = HEADER_BYTES + MAX_PAYLOAD + CRC_BYTES;
   localparam logic [7:0]  FullPos    = 8'(FULL_BYTES);

   logic [7:0]  pos_ff,   pos_in;
   logic [31:0] xfer_ff,  xfer_in;
   logic [31:0] seq_ff,   seq_in;
   logic [31:0] total_ff, total_in;
   logic [15:0] hlen_ff,  hlen_in;
   logic [31:0] crc_ff,   crc_in;
   logic [31:0] trail_ff, trail_in;

   logic [31:0] crc_nx, trail_nx;
   logic [7:0]  pos_nx;
   logic [16:0] len_wide, len_expect;
   logic        in_use;

   assign in_use = pos_ff < FullPos;

   // Byte update, then clear at end of packet
   always_comb begin
      xfer_in  = xfer_ff;
      seq_in   = seq_ff;
      total_in = total_ff;
      hlen_in  = hlen_ff;
      crc_nx   = crc_ff;
      trail_nx = trail_ff;
      pos_nx   = pos_ff;
      if (take && in_use) begin
         if (pos_ff < 8'd4) begin
            xfer_in[8*pos_ff[1:0] +: 8] = data_byte;
         end else if (pos_ff < 8'd8) begin
            seq_in[8*pos_ff[1:0] +: 8] = data_byte;
         end else if (pos_ff < 8'd12) begin
            total_in[8*pos_ff[1:0] +: 8] = data_byte;
         end else if (pos_ff >= 8'd16 && pos_ff < 8'd18) begin
            hlen_in[8*pos_ff[0] +: 8] = data_byte;
         end
         // byte leaves the four-byte delay line into the CRC
         if (pos_ff >= 8'd4) begin
            crc_nx = crc_byte(crc_ff, trail_ff[7:0]);
         end
         trail_nx = {data_byte, trail_ff[31:8]};
         pos_nx   = pos_ff + 8'd1;
      end
      crc_in   = crc_nx;
      trail_in = trail_nx;
      pos_in   = pos_nx;
      if (take && last_byte) begin
         pos_in   = '0;
         xfer_in  = '0;
         seq_in   = '0;
         total_in = '0;
         hlen_in  = '0;
         crc_in   = CRC_INIT;
         trail_in = '0;
      end
   end

   // Packet summary
   assign len_wide   = {9'd0, pos_nx};
   assign len_expect = 17'(MIN_BYTES) + {1'b0, hlen_ff};

   always_comb begin
      pkt.judge       = take && last_byte && (pos_nx >= 8'(MIN_BYTES));
      pkt.len_ok      = (hlen_ff <= 16'(MAX_PAYLOAD))
                        && ((len_wide == len_expect) || (pos_nx == FullPos));
      pkt.crc_ok      = (~crc_nx) == trail_nx;
      pkt.transfer    = xfer_ff;
      pkt.sequence_no = seq_ff;
      pkt.total       = total_ff;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         xfer_ff  <= '0;
         seq_ff   <= '0;
         total_ff <= '0;
         hlen_ff  <= '0;
         crc_ff   <= CRC_INIT;
         trail_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         xfer_ff  <= xfer_in;
         seq_ff   <= seq_in;
         total_ff <= total_in;
         hlen_ff  <= hlen_in;
         crc_ff   <= crc_in;
         trail_ff <= trail_in;
      end
   end

endmodule

// File: rtl/firmware_packet_receive_checker_top.sv
// Result timing: a result is registered and presented in the cycle after the last byte of a packet is taken.
// Throughput: one byte per cycle unless a last byte stalls; CRC-32 takes a full byte in one unrolled step.
// A last byte waits only while a previous result is still held and stalled.
// Reset: synchronous, active high; clears packet state, expected number to one, counters to zero.
// ---------------------------------------------------------------------------
// firmware_packet_receive_checker_top
// Byte-stream firmware packet checker: header parse, CRC-32, ordering and counters.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module firmware_packet_receive_checker_top
   import fprc_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_transfer_number,
   output logic [31:0] rsp_sequence_number,
   output logic        rsp_reply_code,
   output logic [1:0]  rsp_order_status,
   output logic        rsp_transfer_done,
   output logic [31:0] rsp_good_count,
   output logic [31:0] rsp_lost_count
);

   pkt_type     pkt;
   logic        take, produce, new_xfer;
   logic [31:0] exp_ff, exp_in;
   logic [31:0] rcv_ff, rcv_in, rcv_base;
   logic [31:0] mis_ff, mis_in, mis_base;
   logic        code_c, done_c;
   logic [1:0]  status_c;

   logic        valid_ff, valid_in;
   logic [31:0] xfer_ff, seq_ff, good_ff, lost_ff;
   logic        code_ff, done_ff;
   logic [1:0]  status_ff;

   // A last byte needs a free result slot; other bytes always flow
   assign req_stall = req_last_byte && valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   fprc_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .pkt       (pkt)
   );

   // Ordering and counters
   assign new_xfer = (pkt.sequence_no == 32'd1) && (exp_ff == 32'd1);
   assign rcv_base = new_xfer ? '0 : rcv_ff;
   assign mis_base = new_xfer ? '0 : mis_ff;
   assign produce  = pkt.judge && pkt.len_ok;

   always_comb begin
      exp_in   = exp_ff;
      rcv_in   = rcv_ff;
      mis_in   = mis_ff;
      code_c   = REPLY_ACK;
      status_c = ORDER_IN_SEQ;
      done_c   = 1'b0;
      if (pkt.judge) begin
         rcv_in = rcv_base;
         mis_in = mis_base;
         if (pkt.len_ok) begin
            if (!pkt.crc_ok) begin
               code_c   = REPLY_NACK;
               status_c = ORDER_NOT_CHECKED;
            end else if (pkt.sequence_no == exp_ff) begin
               rcv_in = rcv_base + 32'd1;
               exp_in = exp_ff + 32'd1;
               done_c = pkt.sequence_no == pkt.total;
            end else if (pkt.sequence_no > exp_ff) begin
               status_c = ORDER_GAP;
               mis_in   = mis_base + (pkt.sequence_no - exp_ff);
               rcv_in   = rcv_base + 32'd1;
               exp_in   = pkt.sequence_no + 32'd1;
               done_c   = pkt.sequence_no == pkt.total;
            end else begin
               status_c = ORDER_STALE;
            end
         end
      end
   end

   // Result slot
   always_comb begin
      valid_in = valid_ff;
      if (produce) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff   <= 32'd1;
         rcv_ff   <= '0;
         mis_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         exp_ff   <= exp_in;
         rcv_ff   <= rcv_in;
         mis_ff   <= mis_in;
         valid_ff <= valid_in;
      end
   end

   // Result payload, loaded only with a new item
   always_ff @(posedge clock) begin
      if (produce) begin
         xfer_ff   <= pkt.transfer;
         seq_ff    <= pkt.sequence_no;
         code_ff   <= code_c;
         status_ff <= status_c;
         done_ff   <= done_c;
         good_ff   <= rcv_in;
         lost_ff   <= mis_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_transfer_number = xfer_ff;
   assign rsp_sequence_number = seq_ff;
   assign rsp_reply_code      = code_ff;
   assign rsp_order_status    = status_ff;
   assign rsp_transfer_done   = done_ff;
   assign rsp_good_count      = good_ff;
   assign rsp_lost_count      = lost_ff;

   // Checks
   `FPRC_ASSERT(a_rsp_after_last, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_byte), "result without a last byte")
   `FPRC_ASSERT(a_nack_unchecked, clock, reset, (rsp_valid && rsp_reply_code == REPLY_NACK) |-> (rsp_order_status == ORDER_NOT_CHECKED), "NACK with ordering status")
   `FPRC_ASSERT(a_done_accepted, clock, reset, (rsp_valid && rsp_transfer_done) |-> (rsp_reply_code == REPLY_ACK && (rsp_order_status == ORDER_IN_SEQ || rsp_order_status == ORDER_GAP)), "done on a packet not accepted")
   `FPRC_ASSERT_NEXT(a_inorder_advance, clock, reset, produce && pkt.crc_ok && pkt.sequence_no == exp_ff, exp_ff == $past(exp_ff) + 32'd1, "expected number did not advance")

endmodule
